/* hdl/ebl_pkg.sv */
// Shared types, codes and constants of the eye-blink animator.
package ebl_pkg;

	localparam int unsigned OPEN_HEIGHT = 5;

	localparam int unsigned HEIGHT_W = 3;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned SPAN_W   = 16;
	localparam int unsigned ROLL_W   = 7;
	localparam int unsigned DELAY_W  = 13;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;

	localparam logic [1:0] PH_OPEN    = 2'd0;
	localparam logic [1:0] PH_CLOSING = 2'd1;
	localparam logic [1:0] PH_CLOSED  = 2'd2;
	localparam logic [1:0] PH_OPENING = 2'd3;

	localparam logic [1:0] KIND_NORMAL = 2'd0;
	localparam logic [1:0] KIND_SLOW   = 2'd1;
	localparam logic [1:0] KIND_DOUBLE = 2'd2;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [2:0] REG_CLOSE_STEP_NORMAL = 3'd0;
	localparam logic [2:0] REG_CLOSE_STEP_SLOW   = 3'd1;
	localparam logic [2:0] REG_HOLD_NORMAL       = 3'd2;
	localparam logic [2:0] REG_HOLD_SLOW         = 3'd3;
	localparam logic [2:0] REG_OPEN_STEP         = 3'd4;
	localparam logic [2:0] REG_NORMAL_LIMIT      = 3'd5;
	localparam logic [2:0] REG_SLOW_LIMIT        = 3'd6;

	localparam logic [HEIGHT_W-1:0] HEIGHT_FULL   = HEIGHT_W'(OPEN_HEIGHT);
	localparam logic [HEIGHT_W-1:0] HEIGHT_CLOSED = HEIGHT_W'(1);

	typedef struct packed {
		logic [SPAN_W-1:0] close_step_normal;
		logic [SPAN_W-1:0] close_step_slow;
		logic [SPAN_W-1:0] hold_normal;
		logic [SPAN_W-1:0] hold_slow;
		logic [SPAN_W-1:0] open_step;
		logic [ROLL_W-1:0] normal_limit;
		logic [ROLL_W-1:0] slow_limit;
	} cfg_t;

endpackage

/* hdl/ebl_cfg.sv */
// Configuration register file with APB-style access.
module ebl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ebl_pkg::ADDR_W-1:0]    paddr,
	input  logic [ebl_pkg::DATA_W-1:0]    pwdata,
	output logic [ebl_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output ebl_pkg::cfg_t                 cfg
);
	import ebl_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.close_step_normal <= SPAN_W'(60);
			cfg_q.close_step_slow   <= SPAN_W'(120);
			cfg_q.hold_normal       <= SPAN_W'(120);
			cfg_q.hold_slow         <= SPAN_W'(250);
			cfg_q.open_step         <= SPAN_W'(60);
			cfg_q.normal_limit      <= ROLL_W'(80);
			cfg_q.slow_limit        <= ROLL_W'(95);
		end else if (wr_en) begin
			unique case (idx)
				REG_CLOSE_STEP_NORMAL: cfg_q.close_step_normal <= pwdata[SPAN_W-1:0];
				REG_CLOSE_STEP_SLOW:   cfg_q.close_step_slow   <= pwdata[SPAN_W-1:0];
				REG_HOLD_NORMAL:       cfg_q.hold_normal       <= pwdata[SPAN_W-1:0];
				REG_HOLD_SLOW:         cfg_q.hold_slow         <= pwdata[SPAN_W-1:0];
				REG_OPEN_STEP:         cfg_q.open_step         <= pwdata[SPAN_W-1:0];
				REG_NORMAL_LIMIT:      cfg_q.normal_limit      <= pwdata[ROLL_W-1:0];
				REG_SLOW_LIMIT:        cfg_q.slow_limit        <= pwdata[ROLL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CLOSE_STEP_NORMAL: prdata = DATA_W'(cfg_q.close_step_normal);
			REG_CLOSE_STEP_SLOW:   prdata = DATA_W'(cfg_q.close_step_slow);
			REG_HOLD_NORMAL:       prdata = DATA_W'(cfg_q.hold_normal);
			REG_HOLD_SLOW:         prdata = DATA_W'(cfg_q.hold_slow);
			REG_OPEN_STEP:         prdata = DATA_W'(cfg_q.open_step);
			REG_NORMAL_LIMIT:      prdata = DATA_W'(cfg_q.normal_limit);
			REG_SLOW_LIMIT:        prdata = DATA_W'(cfg_q.slow_limit);
			default:               prdata = '0;
		endcase
	end

endmodule

/* hdl/ebl_core.sv */
// Input register, blink sequencer state and result register.
module ebl_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ebl_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [ebl_pkg::TIME_W-1:0]     now_ms,
	input  logic [ebl_pkg::ROLL_W-1:0]     type_roll,
	input  logic [ebl_pkg::DELAY_W-1:0]    delay_roll,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ebl_pkg::HEIGHT_W-1:0]   eye_height,
	output logic                           changed,
	output logic [1:0]                     phase
);
	import ebl_pkg::*;

	// input stage
	logic                valid_s1;
	logic                op_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [ROLL_W-1:0]   roll_s1;
	logic [DELAY_W-1:0]  delay_s1;

	// sequencer state
	logic [1:0]          phase_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [TIME_W-1:0]   frame_q;
	logic [TIME_W-1:0]   deadline_q;
	logic [1:0]          kind_q;
	logic                second_q;

	// result register
	logic                out_valid_q;
	logic [HEIGHT_W-1:0] height_out_q;
	logic                changed_q;
	logic [1:0]          phase_out_q;

	logic                in_acc;
	logic                adv;

	logic [1:0]          phase_d;
	logic [HEIGHT_W-1:0] height_d;
	logic [TIME_W-1:0]   frame_d;
	logic [TIME_W-1:0]   deadline_d;
	logic [1:0]          kind_d;
	logic                second_d;
	logic [TIME_W-1:0]   elapsed;
	logic [TIME_W-1:0]   new_deadline;
	logic [SPAN_W-1:0]   close_span;
	logic [SPAN_W-1:0]   hold_span;
	logic [HEIGHT_W:0]   height_up;

	assign adv      = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= op;
			now_s1   <= now_ms;
			roll_s1  <= type_roll;
			delay_s1 <= delay_roll;
		end
	end

	assign elapsed      = now_s1 - frame_q;
	assign new_deadline = now_s1 + TIME_W'(delay_s1);
	assign close_span   = (kind_q == KIND_SLOW) ? cfg.close_step_slow : cfg.close_step_normal;
	assign hold_span    = (kind_q == KIND_SLOW) ? cfg.hold_slow : cfg.hold_normal;
	assign height_up    = {1'b0, height_q} + (HEIGHT_W+1)'(1);

	always_comb begin
		phase_d    = phase_q;
		height_d   = height_q;
		frame_d    = frame_q;
		deadline_d = deadline_q;
		kind_d     = kind_q;
		second_d   = second_q;
		if (op_s1 == OP_RESTART) begin
			phase_d    = PH_OPEN;
			height_d   = HEIGHT_FULL;
			frame_d    = now_s1;
			deadline_d = new_deadline;
			second_d   = 1'b0;
		end else begin
			unique case (phase_q)
				PH_OPEN: begin
					if (now_s1 > deadline_q) begin
						priority if (roll_s1 < cfg.normal_limit) begin
							kind_d = KIND_NORMAL;
						end else if (roll_s1 < cfg.slow_limit) begin
							kind_d = KIND_SLOW;
						end else begin
							kind_d = KIND_DOUBLE;
						end
						phase_d = PH_CLOSING;
						frame_d = now_s1;
					end
				end
				PH_CLOSING: begin
					if (elapsed > TIME_W'(close_span)) begin
						if (height_q <= HEIGHT_W'(2)) begin
							height_d = HEIGHT_CLOSED;
							phase_d  = PH_CLOSED;
						end else begin
							height_d = height_q - HEIGHT_W'(1);
						end
						frame_d = now_s1;
					end
				end
				PH_CLOSED: begin
					if (elapsed > TIME_W'(hold_span)) begin
						phase_d = PH_OPENING;
						frame_d = now_s1;
					end
				end
				PH_OPENING: begin
					if (elapsed > TIME_W'(cfg.open_step)) begin
						if (height_up >= (HEIGHT_W+1)'(OPEN_HEIGHT)) begin
							height_d = HEIGHT_FULL;
							if (kind_q == KIND_DOUBLE && !second_q) begin
								second_d = 1'b1;
								phase_d  = PH_CLOSING;
							end else begin
								phase_d    = PH_OPEN;
								deadline_d = new_deadline;
								second_d   = 1'b0;
							end
						end else begin
							height_d = height_up[HEIGHT_W-1:0];
						end
						frame_d = now_s1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPEN;
			height_q   <= HEIGHT_FULL;
			frame_q    <= '0;
			deadline_q <= '0;
			kind_q     <= KIND_NORMAL;
			second_q   <= 1'b0;
		end else if (adv) begin
			phase_q    <= phase_d;
			height_q   <= height_d;
			frame_q    <= frame_d;
			deadline_q <= deadline_d;
			kind_q     <= kind_d;
			second_q   <= second_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// reported height tracks the stored height; a restart reports no change
	always_ff @(posedge clk) begin
		if (adv) begin
			height_out_q <= height_d;
			changed_q    <= (op_s1 != OP_RESTART) && (height_d != height_q);
			phase_out_q  <= phase_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign eye_height = height_out_q;
	assign changed    = changed_q;
	assign phase      = phase_out_q;

endmodule

/* hdl/eye_blink_animator.sv */
// Top level of the eye-blink animator: configuration registers and sequencer core.
//
//   channel  signals                                       direction
//   input    in_valid/in_stall, op, now_ms, type_roll,    in
//            delay_roll
//   result   out_valid/out_stall, eye_height, changed,    out
//            phase
//   config   psel/penable/pwrite/paddr/pwdata/prdata/     in/out
//            pready
//
// One transaction per clock while the result is not stalled; an accepted
// transaction passes through the input register, then the result register.
// Reset opens the eye at full height with all timers cleared.
// A stalled result holds the input register; input stall rises only when
// both stages are full and the result is stalled.
module eye_blink_animator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ebl_pkg::ADDR_W-1:0]    paddr,
	input  logic [ebl_pkg::DATA_W-1:0]    pwdata,
	output logic [ebl_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [ebl_pkg::TIME_W-1:0]    now_ms,
	input  logic [ebl_pkg::ROLL_W-1:0]    type_roll,
	input  logic [ebl_pkg::DELAY_W-1:0]   delay_roll,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ebl_pkg::HEIGHT_W-1:0]  eye_height,
	output logic                          changed,
	output logic [1:0]                    phase
);
	import ebl_pkg::*;

	cfg_t cfg;

	ebl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ebl_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.now_ms     (now_ms),
		.type_roll  (type_roll),
		.delay_roll (delay_roll),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.eye_height (eye_height),
		.changed    (changed),
		.phase      (phase)
	);

endmodule

/* hdl/ebl_chk.sv */
// Port-level checker for the eye-blink animator and its bind.
module ebl_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ebl_pkg::HEIGHT_W-1:0]  eye_height,
	input logic                          changed,
	input logic [1:0]                    phase
);
	import ebl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(eye_height) && $stable(changed)
			&& $stable(phase))
		else $error("result changed while stalled");

	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> eye_height >= HEIGHT_CLOSED && eye_height <= HEIGHT_FULL)
		else $error("eye height out of range");

	a_closed_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_CLOSED |-> eye_height == HEIGHT_CLOSED)
		else $error("closed phase with eye not shut");

	a_open_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_OPEN |-> eye_height == HEIGHT_FULL)
		else $error("open phase with eye not fully open");

endmodule

bind eye_blink_animator ebl_chk u_ebl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.eye_height (eye_height),
	.changed    (changed),
	.phase      (phase)
);
